FILE: design/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared sizes, operation and status codes, and the controller command
// bundle for the ring-buffer deque.
// ----------------------------------------------------------------------------
package rbd_pkg;

  // Ring size (power of two) and derived widths
  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int OP_W    = 3;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;

  // Operation codes; anything else behaves as a query
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;  // take the request: update pointers, write a slot
    logic load;    // read front/back slots into the result register
  } rbd_cmd_t;

endpackage

FILE: design/rbd_ctrl.sv
// ----------------------------------------------------------------------------
// rbd_ctrl
// Sequencer for the deque: takes one request, runs the slot read, and hands
// the result to the output register when it is free.
// ----------------------------------------------------------------------------
module rbd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output rbd_pkg::rbd_cmd_t cmd
);
  import rbd_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  // Output register can take a new result this cycle
  assign out_free = !out_valid_r || !out_stall;

  // Commands
  assign cmd.accept = (state_r == S_IDLE) && in_valid;
  assign cmd.load   = (state_r == S_READ) && out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (cmd.load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result valid until taken
  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: design/rbd_datapath.sv
// ----------------------------------------------------------------------------
// rbd_datapath
// Slot memory, head pointer and entry count, plus the result register.
// Pointer update and slot write happen on accept; the two slot reads land in
// the result register on load.
// ----------------------------------------------------------------------------
module rbd_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rbd_pkg::rbd_cmd_t                 cmd,
  input  logic [rbd_pkg::OP_W-1:0]          in_op,
  input  logic signed [rbd_pkg::DATA_W-1:0] in_value,
  output logic signed [rbd_pkg::DATA_W-1:0] out_front_value,
  output logic signed [rbd_pkg::DATA_W-1:0] out_back_value,
  output logic [rbd_pkg::COUNT_W-1:0]       out_count,
  output logic                              out_is_empty,
  output logic [rbd_pkg::STAT_W-1:0]        out_status
);
  import rbd_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic              full, empty;
  logic [IDX_W-1:0]  front_addr, back_addr;

  logic [DATA_W-1:0] res_front_r, res_back_r;
  logic [CNT_W-1:0]  res_count_r;
  logic [STAT_W-1:0] res_status_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  // Decode the request: new head, new count, slot write
  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    wr_en      = 1'b0;
    wr_addr    = head_r + count_r[IDX_W-1:0];
    case (in_op)
      OP_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          head_nxt  = head_r - IDX_W'(1);
          wr_addr   = head_r - IDX_W'(1);
          wr_en     = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          if (count_r == CNT_W'(1)) begin
            head_nxt = '0;
          end else if (in_op == OP_POP_FRONT) begin
            head_nxt = head_r + IDX_W'(1);
          end
        end
      end
      default: status_nxt = ST_OK;
    endcase
  end

  // Pointer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.accept) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      status_r <= status_nxt;
    end
  end

  // Slot write
  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) begin
      mem[wr_addr] <= in_value;
    end
  end

  // Read front and back slots into the result register
  assign front_addr = head_r;
  assign back_addr  = head_r + count_r[IDX_W-1:0] - IDX_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_front_r  <= mem[front_addr];
      res_back_r   <= mem[back_addr];
      res_count_r  <= count_r;
      res_status_r <= status_r;
    end
  end

  // Drive zeros for front/back when the deque is empty
  assign out_is_empty    = (res_count_r == '0);
  assign out_front_value = out_is_empty ? '0 : res_front_r;
  assign out_back_value  = out_is_empty ? '0 : res_back_r;
  assign out_count       = COUNT_W'(res_count_r);
  assign out_status      = res_status_r;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above ring size");

  a_head_home: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> head_r == '0)
    else $error("head not at slot zero while empty");

  a_full_push_held: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && full && (in_op == OP_PUSH_FRONT || in_op == OP_PUSH_BACK)
    |=> $stable(count_r) && $stable(head_r) && status_r == ST_FULL)
    else $error("push into full deque changed state");

  a_empty_pop_held: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && empty && (in_op == OP_POP_FRONT || in_op == OP_POP_BACK)
    |=> count_r == '0 && status_r == ST_EMPTY)
    else $error("pop from empty deque changed state");
`endif

endmodule

FILE: design/ring_buffer_deque.sv
// ----------------------------------------------------------------------------
// ring_buffer_deque
// Double-ended queue of signed 32-bit values in a 16-slot ring. Each request
// is push front/back, pop front/back or query, and returns one result.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall   op, value
//   out_     output     out_valid/out_stall front_value, back_value, count,
//                                           is_empty, status
//
// The accept edge of a request updates head, count and the written slot;
// the load edge, once the output register is free, reads the front and
// back slots into it. The single slot memory with its registered read sets this split.
// At most one request is in flight; a new one is taken while the previous
// result still waits in the output register.
// A stalled output holds the result and keeps the next one in the read step.
// Synchronous reset empties the deque; slot contents are not cleared.
// ----------------------------------------------------------------------------
module ring_buffer_deque (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rbd_pkg::OP_W-1:0]          in_op,
  input  logic signed [rbd_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [rbd_pkg::DATA_W-1:0] out_front_value,
  output logic signed [rbd_pkg::DATA_W-1:0] out_back_value,
  output logic [rbd_pkg::COUNT_W-1:0]       out_count,
  output logic                              out_is_empty,
  output logic [rbd_pkg::STAT_W-1:0]        out_status
);
  import rbd_pkg::*;

  rbd_cmd_t cmd;

  // Sequencer
  rbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Storage and pointers
  rbd_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_op           (in_op),
    .in_value        (in_value),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_count       (out_count),
    .out_is_empty    (out_is_empty),
    .out_status      (out_status)
  );

endmodule
